[rtl/core/bfba_pkg.sv]
// Shared types and constants of the best-fit bin allocator.
package bfba_pkg;

  // Table size default and field widths
  localparam int NUM_BINS_DEF = 16;
  localparam int SIZE_W       = 16;
  localparam int TAG_W        = 16;
  localparam int CAP_W        = 16;
  localparam int ACT_W        = 5;
  localparam int BIDX_W       = 4;
  localparam int INUSE_W      = 5;

  // Register reset values
  localparam logic [CAP_W-1:0] CAP_RST = 16'd100;
  localparam logic [ACT_W-1:0] ACT_RST = 5'd16;

  // Input operation codes
  localparam logic MODE_PLACE = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Register map (word index)
  localparam logic REG_BIN_CAPACITY = 1'b0;
  localparam logic REG_ACTIVE_BINS  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic issue;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip_scan;
    logic last_issue;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/core/bfba_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bfba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic                                 rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/bfba_ctrl.sv]
// Sequencer for accept, bin scan, drain and commit of one item.
module bfba_ctrl
  import bfba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.skip_scan ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_COMMIT: begin
        cmd.commit = status.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/bfba_datapath.sv]
// Bin table, best-fit compare, commit logic and output register.
module bfba_datapath
  import bfba_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status,
  // configuration
  input  logic [CAP_W-1:0]   bin_capacity,
  input  logic [ACT_W-1:0]   active_bins,
  // incoming item
  input  logic               in_mode,
  input  logic [SIZE_W-1:0]  in_item_size,
  input  logic [TAG_W-1:0]   in_item_id,
  // result
  output logic               out_valid,
  input  logic               out_ready,
  output logic [TAG_W-1:0]   out_item_tag,
  output logic               out_placed,
  output logic [BIDX_W-1:0]  out_bin_index,
  output logic [SIZE_W-1:0]  out_remaining_after,
  output logic [INUSE_W-1:0] out_bins_in_use
);

  localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int CNT_W = $clog2(NUM_BINS + 1);
  localparam int LIM_W = (CNT_W > ACT_W) ? CNT_W : ACT_W;
  localparam int BXT_W = (IDX_W > BIDX_W) ? IDX_W : BIDX_W;
  localparam int UXT_W = (CNT_W > INUSE_W) ? CNT_W : INUSE_W;

  // Latched item
  logic              op_clear;
  logic [SIZE_W-1:0] op_size;
  logic [TAG_W-1:0]  op_tag;

  // Scan state
  logic [IDX_W-1:0]  scan_addr;
  logic              pend;
  logic [IDX_W-1:0]  pend_addr;
  logic              found;
  logic [IDX_W-1:0]  best_idx;
  logic [CAP_W-1:0]  best_rem;

  // Table state: a bin that is not used holds fill_value
  logic [NUM_BINS-1:0] used;
  logic [CAP_W-1:0]    fill_value;
  logic [CNT_W-1:0]    in_use;

  logic [CAP_W-1:0]  ram_q;
  logic [CAP_W-1:0]  cur_rem;
  logic [CAP_W-1:0]  new_rem;
  logic              ram_we;
  logic [CNT_W-1:0]  in_use_next;
  logic [LIM_W-1:0]  act_ext;
  logic [LIM_W-1:0]  lim_ext;
  logic [CNT_W-1:0]  limit;
  logic [BXT_W-1:0]  best_ext;
  logic [UXT_W-1:0]  in_use_ext;

  // Usable bin count: active_bins capped at the table size
  always_comb begin
    act_ext = LIM_W'(active_bins);
    lim_ext = (act_ext > LIM_W'(NUM_BINS)) ? LIM_W'(NUM_BINS) : act_ext;
    limit   = CNT_W'(lim_ext);
  end

  // Status to the controller
  assign status.skip_scan  = (in_mode == MODE_CLEAR) || (limit == '0);
  assign status.last_issue = ((CNT_W'(scan_addr) + CNT_W'(1)) == limit);
  assign status.out_free   = !out_valid || out_ready;

  // Remaining capacity table
  assign new_rem = best_rem - op_size;
  assign ram_we  = cmd.commit && !op_clear && found;

  bfba_ram #(
    .WIDTH (CAP_W),
    .DEPTH (NUM_BINS)
  ) u_rem_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (best_idx),
    .wr_data (new_rem),
    .rd_en   (cmd.issue),
    .rd_addr (scan_addr),
    .rd_data (ram_q)
  );

  assign cur_rem = used[pend_addr] ? ram_q : fill_value;

  // Count after a placement
  assign in_use_next = used[best_idx] ? in_use : (in_use + CNT_W'(1));

  // Item latch and scan
  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      found <= 1'b0;
    end else begin
      pend <= cmd.issue;
      if (cmd.accept) begin
        found <= 1'b0;
      end else if (pend && (cur_rem >= op_size) && (!found || (cur_rem < best_rem))) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= scan_addr;
    if (cmd.accept) begin
      op_clear  <= (in_mode == MODE_CLEAR);
      op_size   <= in_item_size;
      op_tag    <= in_item_id;
      scan_addr <= '0;
    end else if (cmd.issue) begin
      scan_addr <= scan_addr + IDX_W'(1);
    end
    // best-fit compare, strict less keeps the lowest index on ties
    if (pend && (cur_rem >= op_size) && (!found || (cur_rem < best_rem))) begin
      best_idx <= pend_addr;
      best_rem <= cur_rem;
    end
  end

  // Table flags, fill value and in-use count
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      in_use     <= '0;
      fill_value <= CAP_RST;
    end else if (cmd.commit) begin
      if (op_clear) begin
        used       <= '0;
        in_use     <= '0;
        fill_value <= bin_capacity;
      end else if (found) begin
        used[best_idx] <= 1'b1;
        in_use         <= in_use_next;
      end
    end
  end

  // Output register
  assign best_ext   = BXT_W'(best_idx);
  assign in_use_ext = op_clear ? '0 :
                      (found ? UXT_W'(in_use_next) : UXT_W'(in_use));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item_tag        <= op_tag;
      out_placed          <= found && !op_clear;
      out_bin_index       <= (found && !op_clear) ? best_ext[BIDX_W-1:0] : '0;
      out_remaining_after <= (found && !op_clear) ? new_rem : '0;
      out_bins_in_use     <= in_use_ext[INUSE_W-1:0];
    end
  end

endmodule

[rtl/core/best_fit_bin_allocator_unit.sv]
// Top level of the best-fit bin allocator: register port, controller, datapath.
//
//  Channel  Direction  Handshake            Payload
//  s_axis   in         s_axis_tvalid/tready tdata {item_id, item_size}, tuser mode
//  m_axis   out        m_axis_tvalid/tready tdata {bins_in_use, remaining_after,
//                                           bin_index, item_tag}, tuser placed
//  apb      in         psel/penable/pready  bin_capacity @0x0, active_bins @0x4
//
// A place item reads min(active_bins, NUM_BINS) bins, one bin per cycle from the
// single read port of the capacity RAM, then passes a drain and a commit state.
// A clear, or a place with no usable bin, goes from idle straight to commit.
// A new item is taken while the previous result still sits in the output
// register; commit waits for that register to free. Reset is synchronous and
// leaves all bins empty at capacity 100 with no clearing pass.
module best_fit_bin_allocator_unit
  import bfba_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] item_size, [31:16] item_id
  input  logic        s_axis_tuser,  // [0] mode
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [15:0] item_tag, [19:16] bin_index,
                                     // [35:20] remaining_after, [40:36] bins_in_use
  output logic        m_axis_tuser,  // [0] placed
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CAP_W-1:0]   bin_capacity;
  logic [ACT_W-1:0]   active_bins;
  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic [TAG_W-1:0]   res_tag;
  logic [BIDX_W-1:0]  res_bin;
  logic [SIZE_W-1:0]  res_rem;
  logic [INUSE_W-1:0] res_inuse;

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_capacity <= CAP_RST;
      active_bins  <= ACT_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_BIN_CAPACITY: bin_capacity <= pwdata[CAP_W-1:0];
        REG_ACTIVE_BINS:  active_bins  <= pwdata[ACT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_BIN_CAPACITY: prdata = 32'(bin_capacity);
      REG_ACTIVE_BINS:  prdata = 32'(active_bins);
      default:          prdata = '0;
    endcase
  end

  bfba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bfba_datapath #(
    .NUM_BINS (NUM_BINS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .bin_capacity        (bin_capacity),
    .active_bins         (active_bins),
    .in_mode             (s_axis_tuser),
    .in_item_size        (s_axis_tdata[15:0]),
    .in_item_id          (s_axis_tdata[31:16]),
    .out_valid           (m_axis_tvalid),
    .out_ready           (m_axis_tready),
    .out_item_tag        (res_tag),
    .out_placed          (m_axis_tuser),
    .out_bin_index       (res_bin),
    .out_remaining_after (res_rem),
    .out_bins_in_use     (res_inuse)
  );

  assign m_axis_tdata = {7'd0, res_inuse, res_rem, res_bin, res_tag};

endmodule

[dv/bin_fit_checker.sv]
// Checker for the best-fit bin allocator: predicts each result and compares it.
`timescale 1ns / 100ps

module bin_fit_checker
  import bfba_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] item_size, [31:16] item_id
  input  logic        s_axis_tuser,  // [0] mode
  // result channel
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,  // [15:0] item_tag, [19:16] bin_index,
                                     // [35:20] remaining_after, [40:36] bins_in_use
  input  logic        m_axis_tuser,  // [0] placed
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  // status toward the testbench top
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          placed_seen
);

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               placed;
    logic [BIDX_W-1:0]  bin;
    logic [CAP_W-1:0]   left;
    logic [INUSE_W-1:0] in_use;
  } placement_t;

  // Shadow copy of the registers and the bin table
  logic [CAP_W-1:0] capacity;
  logic [ACT_W-1:0] active;
  logic [CAP_W-1:0] bin_left [NUM_BINS];
  logic             bin_busy [NUM_BINS];

  placement_t expected_placements [$];

  // Best-fit choice for one item; updates the shadow table
  function automatic placement_t predict_placement(input logic mode,
                                                   input logic [SIZE_W-1:0] size,
                                                   input logic [TAG_W-1:0] tag);
    placement_t res;
    int         limit;
    bit         found;
    int         best;
    int         used;
    res     = '0;
    res.tag = tag;
    found   = 1'b0;
    best    = 0;
    used    = 0;
    if (mode == MODE_CLEAR) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        bin_left[i] = capacity;
        bin_busy[i] = 1'b0;
      end
    end else begin
      limit = (active > NUM_BINS) ? NUM_BINS : active;
      for (int i = 0; i < limit; i++) begin
        // strict less-than keeps the lowest index on ties
        if (bin_left[i] >= size && (!found || bin_left[i] < bin_left[best])) begin
          found = 1'b1;
          best  = i;
        end
      end
      if (found) begin
        bin_left[best] = bin_left[best] - size;
        bin_busy[best] = 1'b1;
        res.placed     = 1'b1;
        res.bin        = best[BIDX_W-1:0];
        res.left       = bin_left[best];
      end
    end
    for (int i = 0; i < NUM_BINS; i++) begin
      if (bin_busy[i]) used++;
    end
    res.in_use = used[INUSE_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Track writes, reads, accepted items and accepted results
  always @(posedge clk) begin
    placement_t want;
    placement_t next_want;
    logic [31:0] reg_want;
    if (rst) begin
      capacity = CAP_RST;
      active   = ACT_RST;
      for (int i = 0; i < NUM_BINS; i++) begin
        bin_left[i] = CAP_RST;
        bin_busy[i] = 1'b0;
      end
      expected_placements.delete();
      errors       = 0;
      results_seen = 0;
      placed_seen  = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_ACTIVE_BINS) active = pwdata[ACT_W-1:0];
          else capacity = pwdata[CAP_W-1:0];
        end else begin
          reg_want = (paddr[2] == REG_ACTIVE_BINS) ? 32'(active) : 32'(capacity);
          check_field("register readback", 64'(reg_want), 64'(prdata));
        end
      end
      // results are matched before this edge's input is queued
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_placements.size() == 0) begin
          $display("%0t: result with tag %0d arrived with none expected",
                   $time, m_axis_tdata[15:0]);
          errors++;
        end else begin
          want = expected_placements.pop_front();
          if (want.placed) placed_seen++;
          check_field("item_tag", 64'(want.tag), 64'(m_axis_tdata[15:0]));
          check_field("placed", 64'(want.placed), 64'(m_axis_tuser));
          check_field("bin_index", 64'(want.bin), 64'(m_axis_tdata[19:16]));
          check_field("remaining_after", 64'(want.left), 64'(m_axis_tdata[35:20]));
          check_field("bins_in_use", 64'(want.in_use), 64'(m_axis_tdata[40:36]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        next_want = predict_placement(s_axis_tuser, s_axis_tdata[15:0],
                                      s_axis_tdata[31:16]);
        expected_placements = {expected_placements, next_want};
      end
    end
    pending = expected_placements.size();
  end

endmodule

[dv/tb_best_fit_bin_allocator_unit.sv]
// Testbench top for the best-fit bin allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_best_fit_bin_allocator_unit;
  import bfba_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 100;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [15:0] item_size, [31:16] item_id
  logic        s_axis_tuser;   // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [15:0] item_tag, [19:16] bin_index,
                               // [35:20] remaining_after, [40:36] bins_in_use
  logic        m_axis_tuser;   // [0] placed
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int results_seen;
  int placed_seen;
  int cycle_count = 0;
  int reg_writes  = 0;
  bit no_idle     = 1'b0;
  bit hold_req    = 1'b0;

  best_fit_bin_allocator_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  bin_fit_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .errors        (errors),
    .pending       (pending),
    .results_seen  (results_seen),
    .placed_seen   (placed_seen)
  );

  always #1 clk = ~clk;

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random back-pressure, one long hold-off on request
  initial begin
    bit held;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        m_axis_tready = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        held = 1'b1;
      end else if (no_idle) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = ($urandom_range(99) >= 29);
      end
    end
  end

  // Offer one item, with random idle gaps; valid stays high afterwards
  task automatic offer_item(input logic mode, input logic [15:0] size,
                            input logic [15:0] id);
    while (!no_idle && $urandom_range(99) < 29) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = $urandom;
      s_axis_tuser  = 1'($urandom);
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {id, size};
    s_axis_tuser  = mode;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // Wait until every queued result has come back
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Register write followed by a readback
  task automatic set_reg(input logic idx, input logic [31:0] value);
    for (int rd = 0; rd < 2; rd++) begin
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = (rd == 0);
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      @(negedge clk);
      psel    = 1'b0;
      penable = 1'b0;
    end
    reg_writes++;
  endtask

  // Mostly sizes within the bin capacity, with zero, full and wide values mixed in
  function automatic logic [15:0] pick_size(input logic [15:0] cap);
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'd0;
    if (r < 16) return cap;
    if (r < 26) return 16'($urandom);
    if (cap > 16'd400 && r < 70) return 16'($urandom_range(0, 400));
    return 16'($urandom_range(0, cap));
  endfunction

  initial begin
    logic [15:0] cap;
    logic [4:0]  act;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_PLACE;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed: reset defaults, exact fit, overflow, zero-size items
    offer_item(MODE_PLACE, 16'd0, 16'h0000);
    offer_item(MODE_PLACE, 16'd100, 16'hFFFF);
    offer_item(MODE_PLACE, 16'd101, 16'h1234);
    offer_item(MODE_PLACE, 16'hFFFF, 16'h5A5A);
    offer_item(MODE_PLACE, 16'd30, 16'hA5A5);
    offer_item(MODE_PLACE, 16'd60, 16'h0001);
    offer_item(MODE_PLACE, 16'd40, 16'h8000);
    offer_item(MODE_PLACE, 16'd0, 16'h7FFF);
    offer_item(MODE_CLEAR, 16'hFFFF, 16'hFFFF);
    // largest capacity, single bin
    drain_results();
    set_reg(REG_BIN_CAPACITY, 32'hFFFF);
    set_reg(REG_ACTIVE_BINS, 32'd1);
    offer_item(MODE_CLEAR, 16'd0, 16'h0010);
    offer_item(MODE_PLACE, 16'hFFFF, 16'h0011);
    offer_item(MODE_PLACE, 16'd1, 16'h0012);
    offer_item(MODE_PLACE, 16'd0, 16'h0013);
    // no usable bin
    drain_results();
    set_reg(REG_ACTIVE_BINS, 32'd0);
    offer_item(MODE_PLACE, 16'd0, 16'h0020);
    offer_item(MODE_PLACE, 16'd5, 16'h0021);
    // active count above table size, zero capacity
    drain_results();
    set_reg(REG_ACTIVE_BINS, 32'd31);
    set_reg(REG_BIN_CAPACITY, 32'd0);
    offer_item(MODE_CLEAR, 16'd7, 16'h0030);
    offer_item(MODE_PLACE, 16'd0, 16'h0031);
    offer_item(MODE_PLACE, 16'd1, 16'h0032);
    // bins beyond a lowered active range still count as used
    drain_results();
    set_reg(REG_BIN_CAPACITY, 32'd100);
    set_reg(REG_ACTIVE_BINS, 32'd16);
    offer_item(MODE_CLEAR, 16'd0, 16'h0040);
    for (int i = 0; i < 3; i++) offer_item(MODE_PLACE, 16'd90, 16'(16'h0041 + i));
    drain_results();
    set_reg(REG_ACTIVE_BINS, 32'd1);
    offer_item(MODE_PLACE, 16'd5, 16'h0050);
    offer_item(MODE_PLACE, 16'd20, 16'h0051);
    // capacity change applies only at the next clear
    drain_results();
    set_reg(REG_BIN_CAPACITY, 32'd50);
    offer_item(MODE_PLACE, 16'd5, 16'h0060);
    offer_item(MODE_CLEAR, 16'd0, 16'h0061);
    offer_item(MODE_PLACE, 16'd50, 16'h0062);

    // Random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       begin cap = 16'd100;                      act = 5'd16; end
        1:       begin cap = 16'hFFFF;                     act = 5'd16; end
        3:       begin cap = 16'd1;                        act = 5'd3;  end
        4:       begin cap = 16'd0;                        act = 5'd8;  end
        6:       begin cap = 16'd200;                      act = 5'd31; end
        7:       begin cap = 16'($urandom_range(1, 1000)); act = 5'd1;  end
        8:       begin cap = 16'($urandom_range(1, 1000)); act = 5'd0;  end
        9:       begin cap = 16'($urandom);  act = 5'($urandom_range(0, 31)); end
        10:      begin cap = 16'd100;                      act = 5'd16; end
        default: begin
          cap = 16'($urandom_range(1, 1000));
          act = 5'($urandom_range(1, 16));
        end
      endcase
      set_reg(REG_BIN_CAPACITY, 32'(cap));
      set_reg(REG_ACTIVE_BINS, 32'(act));
      no_idle = (phase == 3);
      if (phase == 5) hold_req = 1'b1;
      if ($urandom_range(9) < 7) offer_item(MODE_CLEAR, 16'($urandom), 16'($urandom));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < 5) offer_item(MODE_CLEAR, 16'($urandom), 16'($urandom));
        else offer_item(MODE_PLACE, pick_size(cap), 16'($urandom));
      end
    end
    no_idle = 1'b0;

    // Wind down and report
    drain_results();
    repeat (40) @(negedge clk);
    $display("Run covered %0d results (%0d placed, %0d refused or clears)",
             results_seen, placed_seen, results_seen - placed_seen);
    $display("under %0d register settings, with back-pressure and a long receiver stall",
             reg_writes);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/bfba_pkg.sv
rtl/core/bfba_ram.sv
rtl/core/bfba_ctrl.sv
rtl/core/bfba_datapath.sv
rtl/core/best_fit_bin_allocator_unit.sv
dv/bin_fit_checker.sv
dv/tb_best_fit_bin_allocator_unit.sv
